@@ sv/sdgs_pkg.sv @@
// ----------------------------------------------------------------------------
// sdgs_pkg: shared types and constants of the sidechain ducking gain smoother
// Field widths, register indexes, reset values and the job record that
// travels from the smoothing front end to the per-target back end.
// ----------------------------------------------------------------------------
package sdgs_pkg;

  // Field widths
  localparam int DB_W        = 16;   // dB values, Q8.8
  localparam int COEFF_W     = 16;   // coefficients, Q0.16
  localparam int OFS_W       = 14;   // per-target offsets and adjustments
  localparam int MASK_W      = 8;    // target presence mask
  localparam int SLOT_PORT_W = 3;    // target_slot field
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Derived arithmetic widths
  localparam int DIFF_W = DB_W + 1;                // target minus gain
  localparam int PROD_W = DIFF_W + COEFF_W + 1;    // coefficient times difference
  localparam int STEP_W = PROD_W - COEFF_W;        // product after dropping fraction
  localparam int SUM_W  = DIFF_W + 1;              // offset plus gain change

  localparam int ROUND_HALF   = 32768;
  localparam int SNAP_LIMIT   = 2;                 // just under 0.01 dB
  localparam int OFFSET_MIN   = -6144;             // -24 dB
  localparam int MASK_SLOTS   = 8;
  localparam int NUM_TARGETS_DEF = 8;

  // Reset values of the configuration registers
  localparam logic signed [DB_W-1:0]  DUCK_AMOUNT_RST  = -16'sd2560;
  localparam logic signed [DB_W-1:0]  THRESHOLD_RST    = -16'sd10240;
  localparam logic [COEFF_W-1:0]      ATTACK_RST       = 16'd16384;
  localparam logic [COEFF_W-1:0]      RELEASE_RST      = 16'd4096;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUCK_AMOUNT,
    REG_SILENCE_THRESHOLD,
    REG_ATTACK_COEFF,
    REG_RELEASE_COEFF
  } cfg_reg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_FIN
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_WALK
  } back_state_t;

  // One frame's worth of work for the back end
  typedef struct packed {
    logic signed [DIFF_W-1:0] change;
    logic                     duck;
    logic signed [DB_W-1:0]   level;
    logic [MASK_W-1:0]        mask;
  } job_t;

endpackage

@@ sv/sdgs_front.sv @@
// ----------------------------------------------------------------------------
// sdgs_front: item intake and gain smoothing
// Holds the configuration registers and the smoothed gain, runs the one-pole
// update of one item (capture, multiply, round and snap) and hands a job to the queue.
// ----------------------------------------------------------------------------
module sdgs_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [sdgs_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [sdgs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic signed [sdgs_pkg::DB_W-1:0]       in_peak_left,
  input  logic signed [sdgs_pkg::DB_W-1:0]       in_peak_right,
  input  logic                                   in_source_present,
  input  logic [sdgs_pkg::MASK_W-1:0]            in_target_present_mask,
  input  logic                                   q_full,
  output logic                                   q_push,
  output sdgs_pkg::job_t                         q_job
);
  import sdgs_pkg::*;

  front_state_t               st_r, st_nxt;
  logic signed [DB_W-1:0]     duck_amount_r;
  logic signed [DB_W-1:0]     threshold_r;
  logic [COEFF_W-1:0]         attack_r;
  logic [COEFF_W-1:0]         release_r;
  logic signed [DB_W-1:0]     smooth_r, smooth_nxt;

  logic                       flag_r, flag_nxt;
  logic signed [DB_W-1:0]     target_r, target_nxt;
  logic [COEFF_W-1:0]         coeff_r, coeff_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic [MASK_W-1:0]          mask_r, mask_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;

  logic signed [DB_W-1:0]     peak;
  logic                       flag_in;
  logic signed [DB_W-1:0]     target_in;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [STEP_W-1:0]   step;
  logic signed [STEP_W-1:0]   next_wide;
  logic signed [STEP_W-1:0]   snap_gap;
  logic signed [DB_W-1:0]     next_gain;
  logic signed [DIFF_W-1:0]   change;

  assign peak      = (in_peak_left > in_peak_right) ? in_peak_left : in_peak_right;
  assign flag_in   = peak > threshold_r;
  assign target_in = flag_in ? duck_amount_r : '0;

  // Round to nearest with ties upward, then drop the 16 fraction bits.
  assign rnd       = prod_r + PROD_W'(ROUND_HALF);
  assign step      = rnd[PROD_W-1:COEFF_W];
  assign next_wide = STEP_W'(smooth_r) + step;
  assign snap_gap  = next_wide - STEP_W'(target_r);
  assign next_gain = (snap_gap <= STEP_W'(SNAP_LIMIT) && snap_gap >= -STEP_W'(SNAP_LIMIT))
                     ? target_r : next_wide[DB_W-1:0];
  assign change    = DIFF_W'(next_gain) - DIFF_W'(smooth_r);

  assign in_full = (st_r != F_IDLE);

  always_comb begin
    st_nxt     = st_r;
    smooth_nxt = smooth_r;
    flag_nxt   = flag_r;
    target_nxt = target_r;
    coeff_nxt  = coeff_r;
    diff_nxt   = diff_r;
    mask_nxt   = mask_r;
    prod_nxt   = prod_r;
    q_push     = 1'b0;
    unique case (st_r)
      F_IDLE: begin
        // An item without a source is taken and dropped.
        if (in_push && in_source_present) begin
          flag_nxt   = flag_in;
          target_nxt = target_in;
          coeff_nxt  = flag_in ? attack_r : release_r;
          diff_nxt   = DIFF_W'(target_in) - DIFF_W'(smooth_r);
          mask_nxt   = in_target_present_mask;
          st_nxt     = F_MUL;
        end
      end
      F_MUL: begin
        prod_nxt = PROD_W'($signed({1'b0, coeff_r})) * PROD_W'(diff_r);
        st_nxt   = F_FIN;
      end
      F_FIN: begin
        if (!q_full) begin
          smooth_nxt = next_gain;
          q_push     = 1'b1;
          st_nxt     = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  assign q_job.change = change;
  assign q_job.duck   = flag_r;
  assign q_job.level  = next_gain;
  assign q_job.mask   = mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= F_IDLE;
      smooth_r      <= '0;
      duck_amount_r <= DUCK_AMOUNT_RST;
      threshold_r   <= THRESHOLD_RST;
      attack_r      <= ATTACK_RST;
      release_r     <= RELEASE_RST;
    end else begin
      st_r     <= st_nxt;
      smooth_r <= smooth_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_DUCK_AMOUNT:       duck_amount_r <= $signed(cfg_wdata);
          REG_SILENCE_THRESHOLD: threshold_r   <= $signed(cfg_wdata);
          REG_ATTACK_COEFF:      attack_r      <= cfg_wdata;
          REG_RELEASE_COEFF:     release_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    flag_r   <= flag_nxt;
    target_r <= target_nxt;
    coeff_r  <= coeff_nxt;
    diff_r   <= diff_nxt;
    mask_r   <= mask_nxt;
    prod_r   <= prod_nxt;
  end

endmodule

@@ sv/sdgs_job_queue.sv @@
// ----------------------------------------------------------------------------
// sdgs_job_queue: short job queue between front and back end
// A small first-in first-out buffer of frame jobs.
// ----------------------------------------------------------------------------
module sdgs_job_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sdgs_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output sdgs_pkg::job_t  pop_job,
  output logic            empty
);
  import sdgs_pkg::*;

  job_t                q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ sv/sdgs_back.sv @@
// ----------------------------------------------------------------------------
// sdgs_back: per-target offset walk
// Takes one job at a time, visits the target slots in order, updates each
// present target's clamped offset and emits one result per slot.
// ----------------------------------------------------------------------------
module sdgs_back #(
  parameter int NUM_TARGETS = sdgs_pkg::NUM_TARGETS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_empty,
  input  sdgs_pkg::job_t                          q_job,
  output logic                                    q_pop,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic [sdgs_pkg::SLOT_PORT_W-1:0]        out_target_slot,
  output logic signed [sdgs_pkg::OFS_W-1:0]       out_volume_adjust,
  output logic                                    out_adjust_valid,
  output logic signed [sdgs_pkg::OFS_W-1:0]       out_applied_offset,
  output logic                                    out_ducking_active,
  output logic signed [sdgs_pkg::DB_W-1:0]        out_duck_level,
  output logic                                    out_last
);
  import sdgs_pkg::*;

  // Only the first eight slots have a mask bit and give results.
  localparam int EMIT   = (NUM_TARGETS < MASK_SLOTS) ? NUM_TARGETS : MASK_SLOTS;
  localparam int SLOT_W = (EMIT > 1) ? $clog2(EMIT) : 1;

  back_state_t                 bst_r, bst_nxt;
  job_t                        job_r, job_nxt;
  logic [SLOT_PORT_W-1:0]      slot_r, slot_nxt;
  logic signed [OFS_W-1:0]     ofs_r [EMIT];
  logic                        out_v_r, out_v_nxt;

  logic                        adv, emit, last_slot, present;
  logic [SLOT_W-1:0]           idx;
  logic signed [OFS_W-1:0]     old_ofs, new_ofs, adj;
  logic signed [SUM_W-1:0]     sum, clamped;

  assign adv       = !out_v_r || out_pop;
  assign last_slot = (slot_r == SLOT_PORT_W'(EMIT - 1));
  assign idx       = slot_r[SLOT_W-1:0];
  assign old_ofs   = ofs_r[idx];
  assign present   = job_r.mask[slot_r];

  always_comb begin
    sum = SUM_W'(old_ofs) + SUM_W'(job_r.change);
    if (sum < SUM_W'(OFFSET_MIN)) begin
      clamped = SUM_W'(OFFSET_MIN);
    end else if (sum > SUM_W'(0)) begin
      clamped = '0;
    end else begin
      clamped = sum;
    end
    if (present && job_r.change != '0) begin
      new_ofs = clamped[OFS_W-1:0];
    end else begin
      new_ofs = old_ofs;
    end
    adj = new_ofs - old_ofs;
  end

  always_comb begin
    bst_nxt  = bst_r;
    slot_nxt = slot_r;
    job_nxt  = job_r;
    q_pop    = 1'b0;
    emit     = 1'b0;
    unique case (bst_r)
      B_IDLE: begin
        if (!q_empty) begin
          job_nxt  = q_job;
          q_pop    = 1'b1;
          slot_nxt = '0;
          bst_nxt  = B_WALK;
        end
      end
      B_WALK: begin
        if (adv) begin
          emit = 1'b1;
          if (last_slot) begin
            bst_nxt = B_IDLE;
          end else begin
            slot_nxt = slot_r + SLOT_PORT_W'(1);
          end
        end
      end
      default: bst_nxt = B_IDLE;
    endcase
    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  assign out_empty = !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r   <= B_IDLE;
      out_v_r <= 1'b0;
      for (int i = 0; i < EMIT; i++) begin
        ofs_r[i] <= '0;
      end
    end else begin
      bst_r   <= bst_nxt;
      out_v_r <= out_v_nxt;
      if (emit) begin
        ofs_r[idx] <= new_ofs;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    slot_r <= slot_nxt;
    if (emit) begin
      out_target_slot    <= slot_r;
      out_volume_adjust  <= adj;
      out_adjust_valid   <= present && adj != '0;
      out_applied_offset <= new_ofs;
      out_ducking_active <= job_r.duck;
      out_duck_level     <= job_r.level;
      out_last           <= last_slot;
    end
  end

endmodule

@@ sv/sidechain_ducking_gain_smoother_core.sv @@
// ----------------------------------------------------------------------------
// sidechain_ducking_gain_smoother_core: sidechain ducker top level
// Joins the smoothing front end, the job queue and the per-target back end.
// ----------------------------------------------------------------------------
// Once per frame the block takes the source bus peaks and the target mask.
// When the source is present the front end runs the one-pole gain update
// (decide, multiply, round and snap) and queues the result; the back end
// then gives one result per target slot, one a cycle while the consumer
// keeps popping, min(NUM_TARGETS, 8) results in all, while the front end is
// free to take the next item. In steady state the frame rate is set by the
// serial walk over the target offsets for all but the smallest target counts,
// and by any hold-off of pop by the consumer. Items without a source are taken
// and give no result. Configuration writes take effect for items taken after
// the write.
module sidechain_ducking_gain_smoother_core #(
  parameter int NUM_TARGETS = sdgs_pkg::NUM_TARGETS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [sdgs_pkg::CFG_IDX_W-1:0]          cfg_addr,
  input  logic [sdgs_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic signed [sdgs_pkg::DB_W-1:0]        in_peak_left,
  input  logic signed [sdgs_pkg::DB_W-1:0]        in_peak_right,
  input  logic                                    in_source_present,
  input  logic [sdgs_pkg::MASK_W-1:0]             in_target_present_mask,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic [sdgs_pkg::SLOT_PORT_W-1:0]        out_target_slot,
  output logic signed [sdgs_pkg::OFS_W-1:0]       out_volume_adjust,
  output logic                                    out_adjust_valid,
  output logic signed [sdgs_pkg::OFS_W-1:0]       out_applied_offset,
  output logic                                    out_ducking_active,
  output logic signed [sdgs_pkg::DB_W-1:0]        out_duck_level,
  output logic                                    out_last
);
  import sdgs_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  job_t  push_job, pop_job;

  sdgs_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_addr               (cfg_addr),
    .cfg_wdata              (cfg_wdata),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_peak_left           (in_peak_left),
    .in_peak_right          (in_peak_right),
    .in_source_present      (in_source_present),
    .in_target_present_mask (in_target_present_mask),
    .q_full                 (q_full),
    .q_push                 (q_push),
    .q_job                  (push_job)
  );

  sdgs_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  sdgs_back #(
    .NUM_TARGETS (NUM_TARGETS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_job              (pop_job),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_target_slot    (out_target_slot),
    .out_volume_adjust  (out_volume_adjust),
    .out_adjust_valid   (out_adjust_valid),
    .out_applied_offset (out_applied_offset),
    .out_ducking_active (out_ducking_active),
    .out_duck_level     (out_duck_level),
    .out_last           (out_last)
  );

endmodule
